### sv/span_slot_bitmap_allocator_macros.svh
// Assertion macros shared by the span slot allocator RTL.
// Each macro expands to one labeled concurrent assertion on i_clk that is
// switched off while the synchronous active-low reset i_rst_n is applied.
`ifndef SPAN_SLOT_BITMAP_ALLOCATOR_MACROS_SVH
`define SPAN_SLOT_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SSBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define SSBA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ssba_pkg.sv
// ----------------------------------------------------------------------------
// ssba_pkg
// Shared widths, codes and helper functions of the span slot allocator.
// ----------------------------------------------------------------------------
package ssba_pkg;

    // Field widths of the request and response channels.
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned OFF_W       = 13;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned SLOT_W      = 8;
    localparam int unsigned LIVE_W      = 9;
    localparam int unsigned FILL_W      = 2;

    // Configuration register widths.
    localparam int unsigned CNT_CFG_W   = 9;
    localparam int unsigned BYTES_CFG_W = 10;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam int unsigned CFG_IDX_W   = 1;

    // Bitmap geometry: 64-bit words, six bits of slot position per word.
    localparam int unsigned MAP_BITS    = 64;
    localparam int unsigned BIT_W       = 6;
    localparam int unsigned HINT_W      = 9;
    localparam int unsigned SCAN_W      = 4;
    localparam int unsigned POP_W       = 7;
    localparam int unsigned SLOT_LIMIT  = 256;
    localparam int unsigned CMP_W       = 17;

    // Default values of the top-level parameters.
    localparam int unsigned DEF_MAP_WORDS    = 4;
    localparam int unsigned DEF_SPAN_BYTES   = 8192;
    localparam int unsigned DEF_HEADER_BYTES = 128;

    // Register values after reset.
    localparam logic [CNT_CFG_W-1:0]   SLOT_COUNT_RST = 9'd252;
    localparam logic [BYTES_CFG_W-1:0] SLOT_BYTES_RST = 10'd32;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_MARK  = 2'd1,
        KIND_SWEEP = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_INVALID   = 2'd2,
        ST_MARKED    = 2'd3
    } t_status;

    typedef enum logic [FILL_W-1:0] {
        FILL_EMPTY   = 2'd0,
        FILL_PARTIAL = 2'd1,
        FILL_FULL    = 2'd2
    } t_fill;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_COUNT = 1'b0,
        CFG_SLOT_BYTES = 1'b1
    } t_cfg_idx;

    // Position of the lowest set bit, found by halving the word six times.
    function automatic logic [BIT_W-1:0] lowest_one(input logic [MAP_BITS-1:0] v);
        logic [MAP_BITS-1:0] x;
        logic [BIT_W-1:0]    p;
        x = v;
        p = '0;
        for (int s = BIT_W - 1; s >= 0; s--) begin
            if ((x & ((64'd1 << (1 << s)) - 64'd1)) == 64'd0) begin
                p[s] = 1'b1;
                x    = x >> (1 << s);
            end
        end
        return p;
    endfunction

    // Population count of one bitmap word as a six-level adder tree.
    function automatic logic [POP_W-1:0] pop_word(input logic [MAP_BITS-1:0] v);
        logic [MAP_BITS-1:0] x;
        x = v;
        x = (x & 64'h5555_5555_5555_5555) + ((x >> 1)  & 64'h5555_5555_5555_5555);
        x = (x & 64'h3333_3333_3333_3333) + ((x >> 2)  & 64'h3333_3333_3333_3333);
        x = (x & 64'h0F0F_0F0F_0F0F_0F0F) + ((x >> 4)  & 64'h0F0F_0F0F_0F0F_0F0F);
        x = (x & 64'h00FF_00FF_00FF_00FF) + ((x >> 8)  & 64'h00FF_00FF_00FF_00FF);
        x = (x & 64'h0000_FFFF_0000_FFFF) + ((x >> 16) & 64'h0000_FFFF_0000_FFFF);
        x = (x & 64'h0000_0000_FFFF_FFFF) + ((x >> 32) & 64'h0000_0000_FFFF_FFFF);
        return x[POP_W-1:0];
    endfunction

endpackage

### sv/ssba_req_if.sv
// ----------------------------------------------------------------------------
// ssba_req_if
// Request channel of the span slot allocator: operation kind and byte offset.
// ----------------------------------------------------------------------------
interface ssba_req_if import ssba_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  byte_offset;

    modport source (output valid, output kind, output byte_offset, input ready);
    modport sink   (input valid, input kind, input byte_offset, output ready);

endinterface

### sv/ssba_rsp_if.sv
// ----------------------------------------------------------------------------
// ssba_rsp_if
// Response channel of the span slot allocator: status, slot and span fill.
// ----------------------------------------------------------------------------
interface ssba_rsp_if import ssba_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [LIVE_W-1:0]   live_slots;
    logic [FILL_W-1:0]   fill_state;

    modport source (output valid, output status, output slot_index,
                    output live_slots, output fill_state, input ready);
    modport sink   (input valid, input status, input slot_index,
                    input live_slots, input fill_state, output ready);

endinterface

### sv/span_slot_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Span slot bitmap allocator: slot manager for one span of a mark-sweep heap.
// Clear answers at once; allocate scans words from the hint; sweep visits every word.
// Mark runs the divider first. One request at a time; ready returns after the response.
// Reset clears maps, hint and live count and loads slot_count 252, slot_bytes 32.
// ----------------------------------------------------------------------------
`include "span_slot_bitmap_allocator_macros.svh"

module span_slot_bitmap_allocator import ssba_pkg::*; #(
    parameter int unsigned MAP_WORDS    = DEF_MAP_WORDS,
    parameter int unsigned SPAN_BYTES   = DEF_SPAN_BYTES,
    parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ssba_req_if.sink              i_req,
    ssba_rsp_if.source            o_rsp
);

    localparam int unsigned WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned CAND_W     = SCAN_W + BIT_W;
    localparam int unsigned USABLE_MAX = (MAP_WORDS * MAP_BITS < SLOT_LIMIT) ?
                                         MAP_WORDS * MAP_BITS : SLOT_LIMIT;
    localparam logic [CMP_W-1:0] SPAN_LIM = CMP_W'(SPAN_BYTES);
    localparam logic [CMP_W-1:0] HDR_LIM  = CMP_W'(HEADER_BYTES);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ALLOC = 6'b000010,
        S_DIV   = 6'b000100,
        S_MARK  = 6'b001000,
        S_SWEEP = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Bitmap storage; a word whose valid bit is low reads as all zeros.
    logic [MAP_BITS-1:0]    r_alloc [MAP_WORDS];
    logic [MAP_BITS-1:0]    r_mark  [MAP_WORDS];
    logic [MAP_WORDS-1:0]   r_wvld, n_wvld;

    t_state                 r_state, n_state;
    logic [CNT_CFG_W-1:0]   r_slot_count;
    logic [BYTES_CFG_W-1:0] r_slot_bytes;
    logic [HINT_W-1:0]      r_hint, n_hint;
    logic [LIVE_W-1:0]      r_live, n_live;
    logic [LIVE_W-1:0]      r_pop, n_pop;
    logic [SCAN_W-1:0]      r_scan, n_scan;
    logic [OFF_W-1:0]       r_off, n_off;
    t_status                r_status, n_status;
    logic [SLOT_W-1:0]      r_slot, n_slot;

    logic [CNT_CFG_W-1:0]   usable;
    logic [WORD_W-1:0]      rd_idx;
    logic [MAP_BITS-1:0]    alloc_rd;
    logic [MAP_BITS-1:0]    mark_rd;
    logic                   wr_en;
    logic [MAP_BITS-1:0]    wr_alloc;
    logic [MAP_BITS-1:0]    wr_mark;
    logic [MAP_BITS-1:0]    swept;
    logic [BIT_W-1:0]       free_pos;
    logic [CAND_W-1:0]      cand;
    logic [CMP_W-1:0]       off_ext;
    logic                   mark_bad;
    logic                   div_start;
    logic                   div_done;
    logic [OFF_W-1:0]       div_quot;
    logic                   req_take;
    logic                   rsp_fail;
    t_fill                  fill;

    // Slot offset to index: (offset - header) / slot size.
    ssba_div #(
        .NUM_W (OFF_W),
        .DEN_W (BYTES_CFG_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (i_req.byte_offset - OFF_W'(HEADER_BYTES)),
        .i_den   (r_slot_bytes),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Usable slot count and fill level of the span.
    always_comb begin
        usable = (r_slot_count > CNT_CFG_W'(USABLE_MAX)) ? CNT_CFG_W'(USABLE_MAX)
                                                         : r_slot_count;
        if (r_live == '0) begin
            fill = FILL_EMPTY;
        end else if (r_live >= LIVE_W'(usable)) begin
            fill = FILL_FULL;
        end else begin
            fill = FILL_PARTIAL;
        end
    end

    // Mark target checks and the single bitmap read port.
    always_comb begin
        off_ext  = CMP_W'(r_off);
        mark_bad = (off_ext < HDR_LIM) || (off_ext >= SPAN_LIM) ||
                   (r_slot_bytes == '0) || (div_quot >= OFF_W'(usable));
        if (r_state == S_MARK) begin
            rd_idx = mark_bad ? '0 : div_quot[WORD_W+BIT_W-1:BIT_W];
        end else begin
            rd_idx = r_scan[WORD_W-1:0];
        end
        alloc_rd = r_wvld[rd_idx] ? r_alloc[rd_idx] : '0;
        mark_rd  = r_wvld[rd_idx] ? r_mark[rd_idx]  : '0;
        swept    = alloc_rd & mark_rd;
        free_pos = lowest_one(~alloc_rd);
        cand     = {r_scan, free_pos};
    end

    assign req_take    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Sequencer: one word of the bitmaps is visited per cycle.
    always_comb begin
        n_state   = r_state;
        n_wvld    = r_wvld;
        n_hint    = r_hint;
        n_live    = r_live;
        n_pop     = r_pop;
        n_scan    = r_scan;
        n_off     = r_off;
        n_status  = r_status;
        n_slot    = r_slot;
        wr_en     = 1'b0;
        wr_alloc  = alloc_rd;
        wr_mark   = mark_rd;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    case (t_kind'(i_req.kind))
                        KIND_ALLOC: begin
                            n_scan  = SCAN_W'(r_hint[HINT_W-1:BIT_W]);
                            n_state = S_ALLOC;
                        end
                        KIND_MARK: begin
                            n_off     = i_req.byte_offset;
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                        KIND_SWEEP: begin
                            n_scan  = '0;
                            n_pop   = '0;
                            n_state = S_SWEEP;
                        end
                        KIND_CLEAR: begin
                            n_wvld   = '0;
                            n_hint   = '0;
                            n_live   = '0;
                            n_status = ST_OK;
                            n_slot   = '0;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (r_scan >= SCAN_W'(MAP_WORDS)) begin
                    n_status = ST_EXHAUSTED;
                    n_slot   = '0;
                    n_state  = S_DONE;
                end else if (&alloc_rd) begin
                    n_scan = r_scan + SCAN_W'(1);
                end else if (cand >= CAND_W'(usable)) begin
                    n_status = ST_EXHAUSTED;
                    n_slot   = '0;
                    n_state  = S_DONE;
                end else begin
                    wr_en            = 1'b1;
                    wr_alloc         = alloc_rd;
                    wr_alloc[free_pos] = 1'b1;
                    n_wvld[rd_idx]   = 1'b1;
                    n_hint           = HINT_W'(cand) + HINT_W'(1);
                    n_live           = r_live + LIVE_W'(1);
                    n_status         = ST_OK;
                    n_slot           = cand[SLOT_W-1:0];
                    n_state          = S_DONE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                n_state = S_DONE;
                if (mark_bad || !alloc_rd[div_quot[BIT_W-1:0]]) begin
                    n_status = ST_INVALID;
                    n_slot   = '0;
                end else if (mark_rd[div_quot[BIT_W-1:0]]) begin
                    n_status = ST_MARKED;
                    n_slot   = div_quot[SLOT_W-1:0];
                end else begin
                    wr_en                         = 1'b1;
                    wr_mark[div_quot[BIT_W-1:0]]  = 1'b1;
                    n_wvld[rd_idx]                = 1'b1;
                    n_status                      = ST_OK;
                    n_slot                        = div_quot[SLOT_W-1:0];
                end
            end
            S_SWEEP: begin
                if (r_scan >= SCAN_W'(MAP_WORDS)) begin
                    n_live   = r_pop;
                    n_hint   = '0;
                    n_status = ST_OK;
                    n_slot   = '0;
                    n_state  = S_DONE;
                end else begin
                    wr_en          = 1'b1;
                    wr_alloc       = swept;
                    wr_mark        = '0;
                    n_wvld[rd_idx] = 1'b1;
                    n_pop          = r_pop + LIVE_W'(pop_word(swept));
                    n_scan         = r_scan + SCAN_W'(1);
                end
            end
            S_DONE: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wvld       <= '0;
            r_hint       <= '0;
            r_live       <= '0;
            r_slot_count <= SLOT_COUNT_RST;
            r_slot_bytes <= SLOT_BYTES_RST;
        end else begin
            r_state <= n_state;
            r_wvld  <= n_wvld;
            r_hint  <= n_hint;
            r_live  <= n_live;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[CNT_CFG_W-1:0];
                    CFG_SLOT_BYTES: r_slot_bytes <= i_cfg_data[BYTES_CFG_W-1:0];
                    default: begin
                        r_slot_count <= r_slot_count;
                    end
                endcase
            end
        end
    end

    // Working registers and the held response.
    always_ff @(posedge i_clk) begin
        r_pop    <= n_pop;
        r_scan   <= n_scan;
        r_off    <= n_off;
        r_status <= n_status;
        r_slot   <= n_slot;
    end

    // Bitmap word write port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_alloc[rd_idx] <= wr_alloc;
            r_mark[rd_idx]  <= wr_mark;
        end
    end

    assign o_rsp.valid      = (r_state == S_DONE);
    assign o_rsp.status     = r_status;
    assign o_rsp.slot_index = r_slot;
    assign o_rsp.live_slots = r_live;
    assign o_rsp.fill_state = fill;

    // A failed allocation or a rejected mark is being offered.
    assign rsp_fail = o_rsp.valid && (r_status == ST_EXHAUSTED || r_status == ST_INVALID);

    // A request is only taken while no response is pending.
    `SSBA_ASSERT_IMP(a_ready_no_rsp, i_req.ready, !o_rsp.valid, "ready while a response waits")
    // The block is busy in the cycle after it takes a request.
    `SSBA_ASSERT_NXT(a_busy_after_req, req_take, !i_req.ready, "ready held after a request")
    // The live count never exceeds SLOT_LIMIT, the number of slot indices.
    `SSBA_ASSERT_IMP(a_live_bound, 1'b1, r_live <= LIVE_W'(SLOT_LIMIT), "live count too high")
    // Failed allocations and rejected marks report slot zero.
    `SSBA_ASSERT_IMP(a_fail_slot_zero, rsp_fail, r_slot == '0, "slot on a failed request")

endmodule

### sv/ssba_div.sv
// ----------------------------------------------------------------------------
// ssba_div
// Restoring divider that retires one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module ssba_div import ssba_pkg::*; #(
    parameter int unsigned NUM_W = OFF_W,
    parameter int unsigned DEN_W = BYTES_CFG_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quot;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Shift the next numerator bit into the partial remainder and try a subtract.
    always_comb begin
        trial = {r_rem, r_quot[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Remainder and quotient datapath; the numerator is shifted out as the
    // quotient bits are shifted in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
